>>> sv/sjc_pkg.sv
`default_nettype none

package sjc_pkg;

    // Fixed field widths and the default fixed-point position.
    localparam int DATA_W                = 32;
    localparam int ACC_W                 = 64;
    localparam int EPS_W                 = 31;
    localparam int FRACTION_BITS_DEFAULT = 16;

    // Item commands.
    localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
    localparam logic [1:0] CMD_FINISH     = 2'd1;
    localparam logic [1:0] CMD_UPDATE     = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SAT       = 2'd1;
    localparam logic [1:0] STATUS_ZERO_DIAG = 2'd2;

    // Divider step counts.
    localparam int               DIV_CNT_W    = 7;
    localparam logic [DIV_CNT_W-1:0] FINISH_STEPS = 7'd32;
    localparam logic [DIV_CNT_W-1:0] UPDATE_STEPS = 7'd64;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_PASS     = 4'd2;
    localparam logic [3:0] OP_MUL_VS   = 4'd3;
    localparam logic [3:0] OP_ACC_NUM  = 4'd4;
    localparam logic [3:0] OP_ACC_DEN  = 4'd5;
    localparam logic [3:0] OP_MUL_SV   = 4'd6;
    localparam logic [3:0] OP_MUL_SP   = 4'd7;
    localparam logic [3:0] OP_FORM_NUM = 4'd8;
    localparam logic [3:0] OP_STAB     = 4'd9;
    localparam logic [3:0] OP_MAG      = 4'd10;
    localparam logic [3:0] OP_PREP     = 4'd11;
    localparam logic [3:0] OP_DIV      = 4'd12;
    localparam logic [3:0] OP_FIN1     = 4'd13;
    localparam logic [3:0] OP_FIN2     = 4'd14;
    localparam logic [3:0] OP_EMIT     = 4'd15;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [3:0] op;
    } sjc_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       dia_zero;
        logic       div_last;
    } sjc_stat_t;

endpackage

`default_nettype wire

>>> sv/scaled_jacobi_correction_unit.sv
// Accumulate requests pass through the decode and accumulate states; finish and update requests
// run through the divider, and an update with a zero diagonal passes its cell value straight out.
// Only one request is in flight at a time; the one-bit-per-cycle restoring divider takes
// 32 steps for a finish and 64 steps for an update.
// Reset (aresetn low, synchronous) clears both accumulators and the scale factor, sets the
// epsilon register to 1 and empties the output register.
`default_nettype none

module scaled_jacobi_correction_unit #(
    parameter int FRACTION_BITS = sjc_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_we,
    input  wire        [sjc_pkg::EPS_W-1:0]      cfg_wdata,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire        [1:0]                     s_command,
    input  wire signed [sjc_pkg::DATA_W-1:0]     s_cell_value,
    input  wire signed [sjc_pkg::DATA_W-1:0]     s_cell_source,
    input  wire signed [sjc_pkg::DATA_W-1:0]     s_cell_product,
    input  wire signed [sjc_pkg::DATA_W-1:0]     s_cell_diagonal,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [sjc_pkg::DATA_W-1:0]    m_result_value,
    output logic        [1:0]                    m_status
);
    import sjc_pkg::*;

    sjc_ctl_t  ctl;
    sjc_stat_t stat;

    // Sequencer for the request handshakes and the datapath steps.
    sjc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl),
        .stat    (stat)
    );

    // Accumulators, multiplier, divider and output register.
    sjc_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_command       (s_command),
        .s_cell_value    (s_cell_value),
        .s_cell_source   (s_cell_source),
        .s_cell_product  (s_cell_product),
        .s_cell_diagonal (s_cell_diagonal),
        .ctl             (ctl),
        .stat            (stat),
        .m_result_value  (m_result_value),
        .m_status        (m_status)
    );

endmodule

`default_nettype wire

>>> sv/sjc_ctrl.sv
`default_nettype none

module sjc_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire                 m_ready,
    output sjc_pkg::sjc_ctl_t   ctl,
    input  wire sjc_pkg::sjc_stat_t stat
);
    import sjc_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECODE  = 4'd1;
    localparam logic [3:0] ST_ACC_NUM = 4'd2;
    localparam logic [3:0] ST_ACC_DEN = 4'd3;
    localparam logic [3:0] ST_UPD_PRD = 4'd4;
    localparam logic [3:0] ST_UPD_NUM = 4'd5;
    localparam logic [3:0] ST_MAG     = 4'd6;
    localparam logic [3:0] ST_PREP    = 4'd7;
    localparam logic [3:0] ST_DIV     = 4'd8;
    localparam logic [3:0] ST_FIN1    = 4'd9;
    localparam logic [3:0] ST_FIN2    = 4'd10;
    localparam logic [3:0] ST_EMIT    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    // Sequencing of one request through the shared datapath.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        ctl.op       = OP_NONE;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.op     = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.cmd)
                    CMD_ACCUMULATE: begin
                        ctl.op     = OP_MUL_VS;
                        state_next = ST_ACC_NUM;
                    end
                    CMD_FINISH: begin
                        ctl.op     = OP_STAB;
                        state_next = ST_MAG;
                    end
                    CMD_UPDATE: begin
                        if (stat.dia_zero) begin
                            ctl.op     = OP_PASS;
                            state_next = ST_EMIT;
                        end else begin
                            ctl.op     = OP_MUL_SV;
                            state_next = ST_UPD_PRD;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ACC_NUM: begin
                ctl.op     = OP_ACC_NUM;
                state_next = ST_ACC_DEN;
            end
            ST_ACC_DEN: begin
                ctl.op     = OP_ACC_DEN;
                state_next = ST_IDLE;
            end
            ST_UPD_PRD: begin
                ctl.op     = OP_MUL_SP;
                state_next = ST_UPD_NUM;
            end
            ST_UPD_NUM: begin
                ctl.op     = OP_FORM_NUM;
                state_next = ST_MAG;
            end
            ST_MAG: begin
                ctl.op     = OP_MAG;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                ctl.op     = OP_PREP;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                ctl.op = OP_DIV;
                if (stat.div_last) begin
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1: begin
                ctl.op     = OP_FIN1;
                state_next = ST_FIN2;
            end
            ST_FIN2: begin
                ctl.op     = OP_FIN2;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // The output register takes the result once it is free.
                if (!m_valid_reg || m_ready) begin
                    ctl.op       = OP_EMIT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> sv/sjc_datapath.sv
`default_nettype none

module sjc_datapath #(
    parameter int FRACTION_BITS = sjc_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      cfg_we,
    input  wire        [sjc_pkg::EPS_W-1:0]          cfg_wdata,
    input  wire        [1:0]                         s_command,
    input  wire signed [sjc_pkg::DATA_W-1:0]         s_cell_value,
    input  wire signed [sjc_pkg::DATA_W-1:0]         s_cell_source,
    input  wire signed [sjc_pkg::DATA_W-1:0]         s_cell_product,
    input  wire signed [sjc_pkg::DATA_W-1:0]         s_cell_diagonal,
    input  wire        sjc_pkg::sjc_ctl_t            ctl,
    output sjc_pkg::sjc_stat_t                       stat,
    output logic signed [sjc_pkg::DATA_W-1:0]        m_result_value,
    output logic        [1:0]                        m_status
);
    import sjc_pkg::*;

    localparam int SHIFT_HI = DATA_W - FRACTION_BITS;
    localparam int SUM_W    = ACC_W + 2;

    localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] RES_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] RES_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DIV_CNT_W-1:0]     CNT_ONE = 7'd1;

    // Signed add that clamps at the 64-bit limits.
    function automatic logic signed [ACC_W-1:0] sat_add64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
            sat_add64 = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_add64 = s;
        end
    endfunction

    // Item registers.
    logic        [1:0]        cmd_reg, cmd_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] src_reg, src_next;
    logic signed [DATA_W-1:0] prd_reg, prd_next;
    logic signed [DATA_W-1:0] dia_reg, dia_next;

    // Architectural state.
    logic        [EPS_W-1:0]  eps_reg, eps_next;
    logic signed [ACC_W-1:0]  num_sum_reg, num_sum_next;
    logic signed [ACC_W-1:0]  den_sum_reg, den_sum_next;
    logic signed [DATA_W-1:0] sf_reg, sf_next;

    // Working registers.
    logic signed [ACC_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]  t1_reg, t1_next;
    logic signed [ACC_W-1:0]  dvd_reg, dvd_next;
    logic signed [ACC_W-1:0]  dvs_reg, dvs_next;
    logic        [ACC_W-1:0]  mag_a_reg, mag_a_next;
    logic        [ACC_W-1:0]  mag_d_reg, mag_d_next;
    logic                     neg_reg, neg_next;
    logic                     zero_reg, zero_next;
    logic                     ovf_reg, ovf_next;
    logic        [ACC_W-1:0]  rem_reg, rem_next;
    logic        [ACC_W-1:0]  dvx_reg, dvx_next;
    logic        [ACC_W-1:0]  quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]  qs_reg, qs_next;
    logic signed [DATA_W-1:0] pend_val_reg, pend_val_next;
    logic        [1:0]        pend_st_reg, pend_st_next;
    logic signed [DATA_W-1:0] out_val_reg, out_val_next;
    logic        [1:0]        out_st_reg, out_st_next;

    // Shared multiplier and its operand selection.
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  mul_p;

    always_comb begin
        case (ctl.op)
            OP_ACC_NUM: begin
                mul_a = val_reg;
                mul_b = prd_reg;
            end
            OP_MUL_SV: begin
                mul_a = sf_reg;
                mul_b = val_reg;
            end
            OP_MUL_SP: begin
                mul_a = sf_reg;
                mul_b = prd_reg;
            end
            default: begin
                mul_a = val_reg;
                mul_b = src_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Helper values for the individual steps.
    logic        [ACC_W-1:0]  eps_ext;
    logic signed [ACC_W-1:0]  stab_addend;
    logic signed [ACC_W-1:0]  src_ext;
    logic        [ACC_W-1:0]  a_hi;
    logic        [ACC_W-1:0]  a_shl;
    logic        [ACC_W:0]    trial;
    logic        [ACC_W+1:0]  diff;
    logic                     step_ge;
    logic        [SUM_W-1:0]  q_ext;
    logic signed [SUM_W-1:0]  addend;
    logic signed [SUM_W-1:0]  sum;
    logic                     sum_fits;

    assign eps_ext     = {{(ACC_W-EPS_W){1'b0}}, eps_reg};
    assign stab_addend = den_sum_reg[ACC_W-1] ? -eps_ext : eps_ext;
    assign src_ext     = {{(ACC_W-DATA_W){src_reg[DATA_W-1]}}, src_reg};
    assign a_hi        = mag_a_reg >> SHIFT_HI;
    assign a_shl       = mag_a_reg << FRACTION_BITS;
    assign trial       = {rem_reg, dvx_reg[ACC_W-1]};
    assign diff        = {1'b0, trial} - {2'b00, mag_d_reg};
    assign step_ge     = !diff[ACC_W+1];
    assign q_ext       = {2'b00, quo_reg};
    assign addend      = (cmd_reg == CMD_UPDATE) ?
                         {{(SUM_W-ACC_W){t1_reg[ACC_W-1]}}, t1_reg} : '0;
    assign sum         = qs_reg + addend;
    assign sum_fits    = (&sum[SUM_W-1:DATA_W-1]) || !(|sum[SUM_W-1:DATA_W-1]);

    // Next-state logic for every datapath register.
    always_comb begin
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        src_next      = src_reg;
        prd_next      = prd_reg;
        dia_next      = dia_reg;
        eps_next      = eps_reg;
        num_sum_next  = num_sum_reg;
        den_sum_next  = den_sum_reg;
        sf_next       = sf_reg;
        prod_next     = prod_reg;
        t1_next       = t1_reg;
        dvd_next      = dvd_reg;
        dvs_next      = dvs_reg;
        mag_a_next    = mag_a_reg;
        mag_d_next    = mag_d_reg;
        neg_next      = neg_reg;
        zero_next     = zero_reg;
        ovf_next      = ovf_reg;
        rem_next      = rem_reg;
        dvx_next      = dvx_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        qs_next       = qs_reg;
        pend_val_next = pend_val_reg;
        pend_st_next  = pend_st_reg;
        out_val_next  = out_val_reg;
        out_st_next   = out_st_reg;

        if (cfg_we) begin
            eps_next = cfg_wdata;
        end

        case (ctl.op)
            OP_LOAD: begin
                cmd_next = s_command;
                val_next = s_cell_value;
                src_next = s_cell_source;
                prd_next = s_cell_product;
                dia_next = s_cell_diagonal;
            end
            OP_PASS: begin
                pend_val_next = val_reg;
                pend_st_next  = STATUS_ZERO_DIAG;
            end
            OP_MUL_VS, OP_MUL_SV: begin
                prod_next = mul_p;
            end
            OP_ACC_NUM: begin
                num_sum_next = sat_add64(num_sum_reg, prod_reg);
                prod_next    = mul_p;
            end
            OP_ACC_DEN: begin
                den_sum_next = sat_add64(den_sum_reg, prod_reg);
            end
            OP_MUL_SP: begin
                // Floor of sf*value back to the cell format.
                t1_next   = prod_reg >>> FRACTION_BITS;
                prod_next = mul_p;
            end
            OP_FORM_NUM: begin
                dvd_next = (src_ext <<< FRACTION_BITS) - prod_reg;
                dvs_next = {{(ACC_W-DATA_W){dia_reg[DATA_W-1]}}, dia_reg};
            end
            OP_STAB: begin
                // Move the denominator away from zero, then clear the sums.
                dvd_next     = num_sum_reg;
                dvs_next     = sat_add64(den_sum_reg, stab_addend);
                num_sum_next = '0;
                den_sum_next = '0;
            end
            OP_MAG: begin
                mag_a_next = dvd_reg[ACC_W-1] ? -dvd_reg : dvd_reg;
                mag_d_next = dvs_reg[ACC_W-1] ? -dvs_reg : dvs_reg;
                neg_next   = dvd_reg[ACC_W-1] ^ dvs_reg[ACC_W-1];
                zero_next  = (dvs_reg == '0);
            end
            OP_PREP: begin
                quo_next = '0;
                if (cmd_reg == CMD_FINISH) begin
                    // A fraction-shifted quotient at or above 2^32 saturates without dividing.
                    ovf_next = (a_hi >= mag_d_reg);
                    rem_next = a_hi;
                    dvx_next = {a_shl[DATA_W-1:0], {(ACC_W-DATA_W){1'b0}}};
                    cnt_next = FINISH_STEPS;
                end else begin
                    ovf_next  = 1'b0;
                    zero_next = 1'b0;
                    rem_next  = '0;
                    dvx_next  = mag_a_reg;
                    cnt_next  = UPDATE_STEPS;
                end
            end
            OP_DIV: begin
                // One restoring division step per cycle.
                rem_next = step_ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
                dvx_next = {dvx_reg[ACC_W-2:0], 1'b0};
                quo_next = {quo_reg[ACC_W-2:0], step_ge};
                cnt_next = cnt_reg - CNT_ONE;
            end
            OP_FIN1: begin
                qs_next = neg_reg ? ('0 - q_ext) : q_ext;
            end
            OP_FIN2: begin
                if (zero_reg) begin
                    pend_val_next = '0;
                    pend_st_next  = STATUS_SAT;
                end else if (ovf_reg) begin
                    pend_val_next = neg_reg ? RES_MIN : RES_MAX;
                    pend_st_next  = STATUS_SAT;
                end else if (!sum_fits) begin
                    pend_val_next = sum[SUM_W-1] ? RES_MIN : RES_MAX;
                    pend_st_next  = STATUS_SAT;
                end else begin
                    pend_val_next = sum[DATA_W-1:0];
                    pend_st_next  = STATUS_OK;
                end
                if (cmd_reg == CMD_FINISH) begin
                    if (zero_reg) begin
                        sf_next = '0;
                    end else if (ovf_reg) begin
                        sf_next = neg_reg ? RES_MIN : RES_MAX;
                    end else if (!sum_fits) begin
                        sf_next = sum[SUM_W-1] ? RES_MIN : RES_MAX;
                    end else begin
                        sf_next = sum[DATA_W-1:0];
                    end
                end
            end
            OP_EMIT: begin
                out_val_next = pend_val_reg;
                out_st_next  = pend_st_reg;
            end
            default: begin
            end
        endcase
    end

    // State that reset defines.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg     <= {{(EPS_W-1){1'b0}}, 1'b1};
            num_sum_reg <= '0;
            den_sum_reg <= '0;
            sf_reg      <= '0;
        end else begin
            eps_reg     <= eps_next;
            num_sum_reg <= num_sum_next;
            den_sum_reg <= den_sum_next;
            sf_reg      <= sf_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        src_reg      <= src_next;
        prd_reg      <= prd_next;
        dia_reg      <= dia_next;
        prod_reg     <= prod_next;
        t1_reg       <= t1_next;
        dvd_reg      <= dvd_next;
        dvs_reg      <= dvs_next;
        mag_a_reg    <= mag_a_next;
        mag_d_reg    <= mag_d_next;
        neg_reg      <= neg_next;
        zero_reg     <= zero_next;
        ovf_reg      <= ovf_next;
        rem_reg      <= rem_next;
        dvx_reg      <= dvx_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        qs_reg       <= qs_next;
        pend_val_reg <= pend_val_next;
        pend_st_reg  <= pend_st_next;
        out_val_reg  <= out_val_next;
        out_st_reg   <= out_st_next;
    end

    assign stat.cmd      = cmd_reg;
    assign stat.dia_zero = (dia_reg == '0);
    assign stat.div_last = (cnt_reg == CNT_ONE);

    assign m_result_value = out_val_reg;
    assign m_status       = out_st_reg;

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sjc_pkg::*;

    localparam int FRAC = FRACTION_BITS_DEFAULT;

    localparam logic signed [31:0] CELL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CELL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE    = 32'sh0001_0000;
    localparam logic signed [63:0] ACC_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN  = 64'sh8000_0000_0000_0000;

    localparam int PHASE_COUNT     = 5;
    localparam int PHASE_REQUESTS  = 245;
    localparam int SETTLE_CYCLES   = 100;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int PRINT_CAP       = 50;

    typedef struct packed {
        logic [1:0]        command;
        logic signed [31:0] value;
        logic signed [31:0] source;
        logic signed [31:0] product;
        logic signed [31:0] diagonal;
    } cell_request_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } cell_result_t;

    typedef struct {
        cell_request_t req;
        bit            typed;
        cell_result_t  want;
    } plan_row_t;

    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_TOGGLE} ready_pattern_t;

    localparam cell_result_t UNTYPED = '0;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic [EPS_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_command;
    logic signed [DATA_W-1:0] s_cell_value;
    logic signed [DATA_W-1:0] s_cell_source;
    logic signed [DATA_W-1:0] s_cell_product;
    logic signed [DATA_W-1:0] s_cell_diagonal;
    logic m_valid;
    logic m_ready;
    logic signed [DATA_W-1:0] m_result_value;
    logic [1:0] m_status;

    // Predicted block state.
    logic signed [63:0] numerator_acc;
    logic signed [63:0] denominator_acc;
    logic signed [31:0] scale_factor_q;
    logic [30:0]        stab_eps;

    cell_result_t pending_results[$];

    int  mismatch_count = 0;
    int  request_count = 0;
    int  result_count = 0;
    int  zero_diag_count = 0;
    int  saturated_count = 0;
    int  eps_write_count = 0;
    int  burst_left = 0;
    bit  long_hold_req = 1'b0;

    scaled_jacobi_correction_unit #(
        .FRACTION_BITS(FRAC)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_cell_value   (s_cell_value),
        .s_cell_source  (s_cell_source),
        .s_cell_product (s_cell_product),
        .s_cell_diagonal(s_cell_diagonal),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t ns: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Signed 64-bit addition that sticks at the limits.
    function automatic logic signed [63:0] add_clamped64(input logic signed [63:0] a,
                                                         input logic signed [63:0] b);
        logic [64:0] sum;
        sum = {a[63], a} + {b[63], b};
        if (sum[64] != sum[63]) begin
            return sum[64] ? ACC_MIN : ACC_MAX;
        end
        return sum[63:0];
    endfunction

    // (num << FRAC) / den truncated toward zero and clamped to 32 bits.
    function automatic logic signed [31:0] scale_quotient(input logic signed [63:0] num,
                                                          input logic signed [63:0] den,
                                                          output bit clipped);
        logic [63:0]  mag_num;
        logic [63:0]  mag_den;
        logic [127:0] quot;
        bit           negative;
        mag_num = num[63] ? -num : num;
        mag_den = den[63] ? -den : den;
        negative = num[63] ^ den[63];
        clipped = 1'b0;
        if (mag_num / mag_den >= 64'h1_0000_0000) begin
            clipped = 1'b1;
            return negative ? CELL_MIN : CELL_MAX;
        end
        quot = {64'd0, mag_num} << FRAC;
        quot = quot / {64'd0, mag_den};
        if (!negative) begin
            if (quot > 128'h7FFF_FFFF) begin
                clipped = 1'b1;
                return CELL_MAX;
            end
            return quot[31:0];
        end
        if (quot > 128'h8000_0000) begin
            clipped = 1'b1;
            return CELL_MIN;
        end
        return -quot[31:0];
    endfunction

    // Advances the predicted state by one request; returns 1 when a result is due.
    function automatic bit predict_correction(input cell_request_t req,
                                              output cell_result_t res);
        logic signed [63:0] val64;
        logic signed [63:0] src64;
        logic signed [63:0] prd64;
        logic signed [63:0] dia64;
        logic signed [63:0] sf64;
        logic signed [63:0] eps64;
        logic signed [63:0] den;
        logic signed [63:0] total;
        bit                 clipped;
        val64 = $signed(req.value);
        src64 = $signed(req.source);
        prd64 = $signed(req.product);
        dia64 = $signed(req.diagonal);
        res = '0;
        clipped = 1'b0;
        case (req.command)
            CMD_ACCUMULATE: begin
                numerator_acc = add_clamped64(numerator_acc, val64 * src64);
                denominator_acc = add_clamped64(denominator_acc, val64 * prd64);
                return 1'b0;
            end
            CMD_FINISH: begin
                // Push the denominator away from zero by epsilon.
                eps64 = {33'd0, stab_eps};
                if (denominator_acc[63]) begin
                    den = add_clamped64(denominator_acc, -eps64);
                end else begin
                    den = add_clamped64(denominator_acc, eps64);
                end
                if (den == 0) begin
                    res.value = '0;
                    clipped = 1'b1;
                end else begin
                    res.value = scale_quotient(numerator_acc, den, clipped);
                end
                scale_factor_q = res.value;
                numerator_acc = '0;
                denominator_acc = '0;
                res.status = clipped ? STATUS_SAT : STATUS_OK;
                return 1'b1;
            end
            CMD_UPDATE: begin
                if (dia64 == 0) begin
                    res.value = req.value;
                    res.status = STATUS_ZERO_DIAG;
                    return 1'b1;
                end
                // Floor of sf*value plus the truncated Jacobi correction.
                sf64 = scale_factor_q;
                total = ((sf64 * val64) >>> FRAC) + (((src64 <<< FRAC) - sf64 * prd64) / dia64);
                if (total > 64'sh0000_0000_7FFF_FFFF) begin
                    res.value = CELL_MAX;
                    res.status = STATUS_SAT;
                end else if (total < -64'sh0000_0000_8000_0000) begin
                    res.value = CELL_MIN;
                    res.status = STATUS_SAT;
                end else begin
                    res.value = total[31:0];
                    res.status = STATUS_OK;
                end
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // Mostly small Q16.16 values, with full-range words and extremes mixed in.
    function automatic logic signed [31:0] random_cell();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 5))
                    0: return CELL_MIN;
                    1: return CELL_MAX;
                    2: return Q_ONE;
                    3: return -Q_ONE;
                    4: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    function automatic cell_request_t random_request(input logic [1:0] command);
        cell_request_t req;
        req.command = command;
        req.value = random_cell();
        req.source = random_cell();
        req.product = random_cell();
        req.diagonal = random_cell();
        if (command == CMD_UPDATE && $urandom_range(0, 11) == 0) begin
            req.diagonal = '0;
        end
        return req;
    endfunction

    // Offers one request in bursts with random gaps; records its expected result on acceptance.
    task automatic send_request(input cell_request_t req, input bit typed,
                                input cell_result_t want);
        int           gap;
        cell_result_t predicted;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 16);
            gap = $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= req.command;
        s_cell_value <= req.value;
        s_cell_source <= req.source;
        s_cell_product <= req.product;
        s_cell_diagonal <= req.diagonal;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (predict_correction(req, predicted)) begin
            pending_results.push_back(typed ? want : predicted);
        end
        request_count++;
        @(negedge aclk);
    endtask

    // Stops offering requests and lets every expected result come out.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_epsilon(input logic [30:0] eps);
        cfg_we <= 1'b1;
        cfg_wdata <= eps;
        @(negedge aclk);
        cfg_we <= 1'b0;
        stab_eps = eps;
        eps_write_count++;
    endtask

    // Mostly accumulate / finish / update passes, with some stray requests between them.
    task automatic run_phase(input int quota);
        int          sent;
        int          pick;
        int          acc_len;
        int          upd_len;
        logic [1:0]  command;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 99) < 85) begin
                acc_len = $urandom_range(1, 10);
                upd_len = $urandom_range(1, 10);
                repeat (acc_len) send_request(random_request(CMD_ACCUMULATE), 1'b0, UNTYPED);
                send_request(random_request(CMD_FINISH), 1'b0, UNTYPED);
                repeat (upd_len) send_request(random_request(CMD_UPDATE), 1'b0, UNTYPED);
                sent += acc_len + 1 + upd_len;
            end else begin
                pick = $urandom_range(0, 2);
                command = (pick == 0) ? CMD_ACCUMULATE : (pick == 1) ? CMD_FINISH : CMD_UPDATE;
                send_request(random_request(command), 1'b0, UNTYPED);
                sent++;
            end
        end
    endtask

    // Result side: stalls on a changing pattern, plus one long hold-off on request.
    initial begin : result_sink
        ready_pattern_t pattern;
        int             pattern_left;
        int             hold_left;
        m_ready = 1'b0;
        pattern = READY_ALWAYS;
        pattern_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req && hold_left == 0) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern = ready_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 200);
                end
                pattern_left--;
                case (pattern)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    READY_RARELY: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        cell_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%h status=%0d",
                                          m_result_value, m_status));
            end else begin
                want = pending_results.pop_front();
                result_count++;
                if (want.status == STATUS_ZERO_DIAG) zero_diag_count++;
                if (want.status == STATUS_SAT) saturated_count++;
                if (m_result_value !== want.value) begin
                    report_mismatch($sformatf("result %0d: value %h, expected %h",
                                              result_count, m_result_value, want.value));
                end
                if (m_status !== want.status) begin
                    report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                              result_count, m_status, want.status));
                end
            end
        end
    end

    initial begin : stimulus
        plan_row_t   directed_plan [24];
        logic [30:0] eps;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_command = CMD_ACCUMULATE;
        s_cell_value = '0;
        s_cell_source = '0;
        s_cell_product = '0;
        s_cell_diagonal = '0;
        numerator_acc = '0;
        denominator_acc = '0;
        scale_factor_q = '0;
        stab_eps = 31'd1;

        directed_plan = '{
            // Finish right after reset: empty sums give a zero scale factor.
            '{'{CMD_FINISH, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, STATUS_OK}},
            // A zero diagonal passes the cell value through.
            '{'{CMD_UPDATE, CELL_MAX, 32'sd5, 32'sd7, 32'sd0}, 1'b1,
              '{CELL_MAX, STATUS_ZERO_DIAG}},
            '{'{CMD_UPDATE, CELL_MIN, CELL_MIN, CELL_MAX, 32'sd0}, 1'b1,
              '{CELL_MIN, STATUS_ZERO_DIAG}},
            // Scale factor overflow in both directions.
            '{'{CMD_ACCUMULATE, Q_ONE, CELL_MAX, 32'sd0, CELL_MAX}, 1'b0, UNTYPED},
            '{'{CMD_FINISH, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{CELL_MAX, STATUS_SAT}},
            '{'{CMD_ACCUMULATE, Q_ONE, CELL_MIN, 32'sd0, CELL_MIN}, 1'b0, UNTYPED},
            '{'{CMD_FINISH, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{CELL_MIN, STATUS_SAT}},
            // Updates with the extreme scale factor and extreme operands.
            '{'{CMD_UPDATE, CELL_MIN, CELL_MAX, CELL_MIN, 32'sd1}, 1'b0, UNTYPED},
            '{'{CMD_UPDATE, CELL_MAX, CELL_MIN, CELL_MAX, -32'sd1}, 1'b0, UNTYPED},
            // Both sums run into the positive limit.
            '{'{CMD_ACCUMULATE, CELL_MIN, CELL_MIN, CELL_MIN, 32'sd0}, 1'b0, UNTYPED},
            '{'{CMD_ACCUMULATE, CELL_MIN, CELL_MIN, CELL_MIN, 32'sd0}, 1'b0, UNTYPED},
            '{'{CMD_FINISH, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, UNTYPED},
            // Both sums run into the negative limit.
            '{'{CMD_ACCUMULATE, CELL_MIN, CELL_MAX, CELL_MAX, 32'sd0}, 1'b0, UNTYPED},
            '{'{CMD_ACCUMULATE, CELL_MIN, CELL_MAX, CELL_MAX, 32'sd0}, 1'b0, UNTYPED},
            '{'{CMD_ACCUMULATE, CELL_MIN, CELL_MAX, CELL_MAX, 32'sd0}, 1'b0, UNTYPED},
            '{'{CMD_FINISH, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, UNTYPED},
            // Ordinary values: a scale factor just under 3.0.
            '{'{CMD_ACCUMULATE, 32'sh0002_0000, 32'sh0003_0000, Q_ONE, Q_ONE}, 1'b0, UNTYPED},
            '{'{CMD_FINISH, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, UNTYPED},
            '{'{CMD_UPDATE, Q_ONE, 32'sh0002_0000, 32'sh0000_8000, 32'sh0002_0000}, 1'b0,
              UNTYPED},
            '{'{CMD_UPDATE, 32'shFFFE_8000, 32'shFFFF_C000, 32'sh0003_0000, 32'shFFFF_8000},
              1'b0, UNTYPED},
            // Rounding of the smallest positive and negative cell values.
            '{'{CMD_UPDATE, 32'sd1, 32'sd0, 32'sd0, CELL_MAX}, 1'b0, UNTYPED},
            '{'{CMD_UPDATE, -32'sd1, 32'sd0, 32'sd0, CELL_MIN}, 1'b0, UNTYPED},
            // Finish with no accumulation, then an update that saturates high.
            '{'{CMD_FINISH, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, STATUS_OK}},
            '{'{CMD_UPDATE, CELL_MAX, CELL_MAX, CELL_MIN, 32'sd1}, 1'b1, '{CELL_MAX, STATUS_SAT}}
        };

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed requests run with the reset epsilon.
        foreach (directed_plan[i]) begin
            send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
        end

        // Random phases, each under its own epsilon, written while the block is idle.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_for_drain();
            case (phase)
                0: eps = 31'h7FFF_FFFF;
                1: eps = 31'd1;
                2: eps = 31'($urandom_range(1, 1000));
                3: eps = 31'd1 << $urandom_range(0, 30);
                default: eps = 31'($urandom_range(1, 32'h7FFF_FFFF));
            endcase
            write_epsilon(eps);
            if (phase == 2) begin
                long_hold_req = 1'b1;
            end
            run_phase(PHASE_REQUESTS);
        end

        wait_for_drain();
        $display("Sent %0d requests under %0d epsilon settings; checked %0d results.",
                 request_count, eps_write_count, result_count);
        $display("Results included %0d zero-diagonal and %0d saturated cases.",
                 zero_diag_count, saturated_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        #10_000_000;
        $display("Timeout with %0d results still expected.", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
sv/sjc_pkg.sv
sv/sjc_ctrl.sv
sv/sjc_datapath.sv
sv/scaled_jacobi_correction_unit.sv
verif/testbench.sv
